@@ design/setok_pkg.sv @@
// Shared types, token kind codes, lexer modes and character constants of the tokenizer.
package setok_pkg;

  typedef enum logic [3:0] {
    K_END    = 4'd0,
    K_INT    = 4'd1,
    K_RAT    = 4'd2,
    K_FLOAT  = 4'd3,
    K_SYM    = 4'd4,
    K_STR    = 4'd5,
    K_CONST  = 4'd6,
    K_LPAREN = 4'd7,
    K_RPAREN = 4'd8,
    K_DOT    = 4'd9,
    K_TICK   = 4'd10,
    K_ERR    = 4'd11
  } kind_t;

  typedef enum logic [10:0] {
    M_IDLE    = 11'b000_0000_0001,
    M_COMMENT = 11'b000_0000_0010,
    M_INT     = 11'b000_0000_0100,
    M_RSIGN   = 11'b000_0000_1000,
    M_RDIG    = 11'b000_0001_0000,
    M_FRAC    = 11'b000_0010_0000,
    M_MINUS   = 11'b000_0100_0000,
    M_SYM     = 11'b000_1000_0000,
    M_CONST   = 11'b001_0000_0000,
    M_STR     = 11'b010_0000_0000,
    M_ESC     = 11'b100_0000_0000
  } mode_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_TICK   = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6e;
  localparam logic [7:0] CH_LOW_T  = 8'h74;

  // One result word of the output channel.
  typedef struct packed {
    logic [3:0] token_kind;
    logic [7:0] value_char;
    logic       has_char;
    logic       last_of_token;
  } res_t;

  // The results that one input word causes, slot 0 first.
  typedef struct packed {
    res_t [2:0] slot;
    logic [1:0] count;
  } batch_t;

endpackage

@@ design/setok_in_if.sv @@
// Input channel of the tokenizer: one source byte or an end-of-input mark per word.
interface setok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_input;

  modport source(output valid, output char_in, output end_of_input, input ready);
  modport sink(input valid, input char_in, input end_of_input, output ready);
endinterface

@@ design/setok_out_if.sv @@
// Output channel of the tokenizer: one token character or token marker per word.
interface setok_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_kind;
  logic [7:0] value_char;
  logic       has_char;
  logic       last_of_token;

  modport source(output valid, output token_kind, output value_char, output has_char,
                 output last_of_token, input ready);
  modport sink(input valid, input token_kind, input value_char, input has_char,
               input last_of_token, output ready);
endinterface

@@ design/setok_lex.sv @@
// Combinational lexer step: current mode and one input word give the results and next mode.
module setok_lex (
  input  setok_pkg::mode_t  lex_mode,
  input  logic [7:0]        char_in,
  input  logic              end_of_input,
  output setok_pkg::batch_t batch,
  output setok_pkg::mode_t  mode_next
);
  import setok_pkg::*;

  typedef struct packed {
    logic  vld;
    res_t  r;
    mode_t m;
  } start_t;

  function automatic res_t mk(kind_t kind, logic [7:0] ch);
    res_t r;
    r.token_kind    = kind;
    r.value_char    = ch;
    r.has_char      = 1'b1;
    r.last_of_token = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_one(kind_t kind, logic [7:0] ch);
    res_t r;
    r.token_kind    = kind;
    r.value_char    = ch;
    r.has_char      = 1'b1;
    r.last_of_token = 1'b1;
    return r;
  endfunction

  function automatic res_t mk_close(kind_t kind);
    res_t r;
    r.token_kind    = kind;
    r.value_char    = CH_NUL;
    r.has_char      = 1'b0;
    r.last_of_token = 1'b1;
    return r;
  endfunction

  function automatic logic is_white(logic [7:0] c);
    return c inside {CH_SPACE, [CH_TAB:CH_CR]};
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  // Examines a word as the first one of a new token.
  function automatic start_t start_tok(logic [7:0] c, logic eoi);
    start_t s;
    s.vld = 1'b0;
    s.r   = mk_close(K_END);
    s.m   = M_IDLE;
    if (eoi) begin
      s.vld = 1'b1;
    end else if (!is_white(c)) begin
      case (c)
        CH_SEMI:   s.m = M_COMMENT;
        CH_LPAREN: begin s.vld = 1'b1; s.r = mk_one(K_LPAREN, c); end
        CH_RPAREN: begin s.vld = 1'b1; s.r = mk_one(K_RPAREN, c); end
        CH_DOT:    begin s.vld = 1'b1; s.r = mk_one(K_DOT, c); end
        CH_TICK:   begin s.vld = 1'b1; s.r = mk_one(K_TICK, c); end
        CH_QUOTE:  s.m = M_STR;
        CH_HASH:   begin s.vld = 1'b1; s.r = mk(K_CONST, c); s.m = M_CONST; end
        CH_MINUS:  s.m = M_MINUS;
        default: begin
          s.vld = 1'b1;
          if (is_digit(c)) begin
            s.r = mk(K_INT, c);
            s.m = M_INT;
          end else begin
            s.r = mk(K_SYM, c);
            s.m = M_SYM;
          end
        end
      endcase
    end
    return s;
  endfunction

  start_t     st;
  logic       term;
  logic [7:0] esc_char;

  assign st   = start_tok(char_in, end_of_input);
  assign term = end_of_input || is_white(char_in) || (char_in == CH_RPAREN);

  always_comb begin
    case (char_in)
      CH_LOW_N: esc_char = CH_LF;
      CH_LOW_T: esc_char = CH_TAB;
      CH_LOW_F: esc_char = CH_FF;
      default:  esc_char = char_in;
    endcase
  end

  always_comb begin
    batch     = '0;
    mode_next = lex_mode;
    case (lex_mode)
      M_COMMENT: begin
        if (end_of_input) begin
          batch.slot[0] = st.r;
          batch.count   = 2'd1;
          mode_next     = M_IDLE;
        end else if (char_in == CH_LF) begin
          mode_next = M_IDLE;
        end
      end
      M_INT: begin
        if (!end_of_input && is_digit(char_in)) begin
          batch.slot[0] = mk(K_INT, char_in);
          batch.count   = 2'd1;
        end else if (!end_of_input && char_in == CH_SLASH) begin
          batch.slot[0] = mk(K_RAT, char_in);
          batch.count   = 2'd1;
          mode_next     = M_RSIGN;
        end else if (!end_of_input && char_in == CH_DOT) begin
          batch.slot[0] = mk(K_FLOAT, char_in);
          batch.count   = 2'd1;
          mode_next     = M_FRAC;
        end else begin
          batch.slot[0] = mk_close(K_INT);
          batch.slot[1] = st.r;
          batch.count   = st.vld ? 2'd2 : 2'd1;
          mode_next     = st.m;
        end
      end
      M_RSIGN, M_RDIG: begin
        if (!end_of_input && (is_digit(char_in) ||
            (char_in == CH_MINUS && lex_mode == M_RSIGN))) begin
          batch.slot[0] = mk(K_RAT, char_in);
          batch.count   = 2'd1;
          mode_next     = M_RDIG;
        end else begin
          batch.slot[0] = mk_close(K_RAT);
          batch.slot[1] = st.r;
          batch.count   = st.vld ? 2'd2 : 2'd1;
          mode_next     = st.m;
        end
      end
      M_FRAC: begin
        if (!end_of_input && is_digit(char_in)) begin
          batch.slot[0] = mk(K_FLOAT, char_in);
          batch.count   = 2'd1;
        end else begin
          batch.slot[0] = mk_close(K_FLOAT);
          batch.slot[1] = st.r;
          batch.count   = st.vld ? 2'd2 : 2'd1;
          mode_next     = st.m;
        end
      end
      M_MINUS: begin
        if (!end_of_input && is_digit(char_in)) begin
          batch.slot[0] = mk(K_INT, CH_MINUS);
          batch.slot[1] = mk(K_INT, char_in);
          batch.count   = 2'd2;
          mode_next     = M_INT;
        end else if (term) begin
          // The held minus becomes a one-character symbol, closed at once.
          batch.slot[0] = mk(K_SYM, CH_MINUS);
          batch.slot[1] = mk_close(K_SYM);
          batch.slot[2] = st.r;
          batch.count   = st.vld ? 2'd3 : 2'd2;
          mode_next     = st.m;
        end else begin
          batch.slot[0] = mk(K_SYM, CH_MINUS);
          batch.slot[1] = mk(K_SYM, char_in);
          batch.count   = 2'd2;
          mode_next     = M_SYM;
        end
      end
      M_SYM, M_CONST: begin
        if (term) begin
          batch.slot[0] = mk_close((lex_mode == M_SYM) ? K_SYM : K_CONST);
          batch.slot[1] = st.r;
          batch.count   = st.vld ? 2'd2 : 2'd1;
          mode_next     = st.m;
        end else begin
          batch.slot[0] = mk((lex_mode == M_SYM) ? K_SYM : K_CONST, char_in);
          batch.count   = 2'd1;
        end
      end
      M_STR: begin
        if (end_of_input) begin
          batch.slot[0] = mk_close(K_ERR);
          batch.slot[1] = mk_close(K_END);
          batch.count   = 2'd2;
          mode_next     = M_IDLE;
        end else if (char_in == CH_QUOTE) begin
          batch.slot[0] = mk_close(K_STR);
          batch.count   = 2'd1;
          mode_next     = M_IDLE;
        end else if (char_in == CH_BSLASH) begin
          mode_next = M_ESC;
        end else begin
          batch.slot[0] = mk(K_STR, char_in);
          batch.count   = 2'd1;
        end
      end
      M_ESC: begin
        if (end_of_input) begin
          batch.slot[0] = mk_close(K_ERR);
          batch.slot[1] = mk_close(K_END);
          batch.count   = 2'd2;
          mode_next     = M_IDLE;
        end else begin
          batch.slot[0] = mk(K_STR, esc_char);
          batch.count   = 2'd1;
          mode_next     = M_STR;
        end
      end
      default: begin
        batch.slot[0] = st.r;
        batch.count   = st.vld ? 2'd1 : 2'd0;
        mode_next     = st.m;
      end
    endcase
  end

endmodule

@@ design/setok_emit.sv @@
// Result queue of up to three words whose head is the registered output word.
module setok_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  setok_pkg::batch_t batch,
  output logic              free,
  setok_out_if.source       tokens
);
  import setok_pkg::*;

  res_t [2:0] slots;
  logic [1:0] count;
  logic       pop;

  assign tokens.valid         = (count != 2'd0);
  assign tokens.token_kind    = slots[0].token_kind;
  assign tokens.value_char    = slots[0].value_char;
  assign tokens.has_char      = slots[0].has_char;
  assign tokens.last_of_token = slots[0].last_of_token;

  assign pop  = tokens.valid && tokens.ready;
  // A new batch may land when the queue is empty after this cycle.
  assign free = (count == 2'd0) || (count == 2'd1 && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= batch.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= batch.slot;
    end else if (pop) begin
      slots[0] <= slots[1];
      slots[1] <= slots[2];
    end
  end

endmodule

@@ design/s_expression_tokenizer.sv @@
// A byte accepted into the input stage has its results loaded into the result queue.
// The registered head word of the queue is the output word. Throughput: one input word
// per cycle while each word causes at most one result word and ready stays high. After a
// word with more result words (at most three), the next word waits in the input stage
// while the single output port drains the queue, one word a cycle while ready is high.
// Reset (synchronous, active high) empties the input stage and the result queue and
// returns the lexer mode to idle between tokens.
module s_expression_tokenizer (
  input logic         clk,
  input logic         rst,
  setok_in_if.sink    bytes,
  setok_out_if.source tokens
);
  import setok_pkg::*;

  // Input stage. It holds one accepted word until the lexer step can hand its
  // results to the result queue.
  logic       in_vld;
  logic [7:0] in_char;
  logic       in_eoi;

  // Lexer mode, one-hot, carried from one word to the next.
  mode_t      lex_mode;
  mode_t      mode_next;

  batch_t     batch;
  logic       free;
  logic       consume;
  logic       load;

  // The lexer step is pure logic on the held word and the current mode.
  setok_lex u_lex (
    .lex_mode     (lex_mode),
    .char_in      (in_char),
    .end_of_input (in_eoi),
    .batch        (batch),
    .mode_next    (mode_next)
  );

  // A held word is consumed when it yields no results (only the mode moves),
  // or when the result queue is about to be empty and can take the whole batch.
  // Loading the whole batch at once keeps the results of one word together and
  // in order, so nothing has to be tracked per word beyond the queue count.
  assign consume = in_vld && ((batch.count == 2'd0) || free);
  assign load    = consume && (batch.count != 2'd0);

  // The input stage takes a new word whenever it is empty or its word leaves
  // in this cycle, so words can arrive back to back.
  assign bytes.ready = !in_vld || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld   <= 1'b0;
      lex_mode <= M_IDLE;
    end else begin
      if (bytes.valid && bytes.ready) begin
        in_vld <= 1'b1;
      end else if (consume) begin
        in_vld <= 1'b0;
      end
      if (consume) begin
        lex_mode <= mode_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      in_char <= bytes.char_in;
      in_eoi  <= bytes.end_of_input;
    end
  end

  // The result queue drives the output channel from its registered head word.
  setok_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .batch  (batch),
    .free   (free),
    .tokens (tokens)
  );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the s-expression tokenizer with a scoreboard that predicts tokens.
`timescale 1ns / 1ps

import setok_pkg::*;

// Tracks the lexer state for every accepted source word and keeps the token words
// that must come out, oldest first.
class token_scoreboard;
  mode_t lex_state;
  res_t  expected_words[$];
  int    mismatches;

  function new();
    lex_state  = M_IDLE;
    mismatches = 0;
  endfunction

  function bit is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function void push_word(kind_t kind, logic [7:0] c, logic has, logic last);
    res_t w;
    w.token_kind    = kind;
    w.value_char    = c;
    w.has_char      = has;
    w.last_of_token = last;
    expected_words.push_back(w);
  endfunction

  function void close_token(kind_t kind);
    push_word(kind, CH_NUL, 1'b0, 1'b1);
  endfunction

  // Looks at a word as the first one of a new token.
  function void start_token(logic [7:0] c, logic eoi);
    lex_state = M_IDLE;
    if (eoi) begin
      close_token(K_END);
    end else if (!is_space(c)) begin
      case (c)
        CH_SEMI:   lex_state = M_COMMENT;
        CH_LPAREN: push_word(K_LPAREN, c, 1'b1, 1'b1);
        CH_RPAREN: push_word(K_RPAREN, c, 1'b1, 1'b1);
        CH_DOT:    push_word(K_DOT, c, 1'b1, 1'b1);
        CH_TICK:   push_word(K_TICK, c, 1'b1, 1'b1);
        CH_QUOTE:  lex_state = M_STR;
        CH_HASH: begin
          lex_state = M_CONST;
          push_word(K_CONST, c, 1'b1, 1'b0);
        end
        CH_MINUS:  lex_state = M_MINUS;
        default: begin
          if (is_digit(c)) begin
            lex_state = M_INT;
            push_word(K_INT, c, 1'b1, 1'b0);
          end else begin
            lex_state = M_SYM;
            push_word(K_SYM, c, 1'b1, 1'b0);
          end
        end
      endcase
    end
  endfunction

  // Symbols and constants run until whitespace, ')' or the end of input.
  function void extend_word(logic [7:0] c, logic eoi, kind_t kind);
    if (eoi || is_space(c) || c == CH_RPAREN) begin
      close_token(kind);
      start_token(c, eoi);
    end else begin
      push_word(kind, c, 1'b1, 1'b0);
    end
  endfunction

  function void note_byte(logic [7:0] c, logic eoi);
    logic [7:0] t;
    case (lex_state)
      M_COMMENT: begin
        if (eoi) start_token(c, eoi);
        else if (c == CH_LF) lex_state = M_IDLE;
      end
      M_INT: begin
        if (!eoi && is_digit(c)) begin
          push_word(K_INT, c, 1'b1, 1'b0);
        end else if (!eoi && c == CH_SLASH) begin
          push_word(K_RAT, c, 1'b1, 1'b0);
          lex_state = M_RSIGN;
        end else if (!eoi && c == CH_DOT) begin
          push_word(K_FLOAT, c, 1'b1, 1'b0);
          lex_state = M_FRAC;
        end else begin
          close_token(K_INT);
          start_token(c, eoi);
        end
      end
      M_RSIGN, M_RDIG: begin
        if (!eoi && (is_digit(c) || (c == CH_MINUS && lex_state == M_RSIGN))) begin
          push_word(K_RAT, c, 1'b1, 1'b0);
          lex_state = M_RDIG;
        end else begin
          close_token(K_RAT);
          start_token(c, eoi);
        end
      end
      M_FRAC: begin
        if (!eoi && is_digit(c)) begin
          push_word(K_FLOAT, c, 1'b1, 1'b0);
        end else begin
          close_token(K_FLOAT);
          start_token(c, eoi);
        end
      end
      M_MINUS: begin
        if (!eoi && is_digit(c)) begin
          push_word(K_INT, CH_MINUS, 1'b1, 1'b0);
          push_word(K_INT, c, 1'b1, 1'b0);
          lex_state = M_INT;
        end else begin
          push_word(K_SYM, CH_MINUS, 1'b1, 1'b0);
          lex_state = M_SYM;
          extend_word(c, eoi, K_SYM);
        end
      end
      M_SYM:   extend_word(c, eoi, K_SYM);
      M_CONST: extend_word(c, eoi, K_CONST);
      M_STR: begin
        if (eoi) begin
          close_token(K_ERR);
          start_token(c, eoi);
        end else if (c == CH_QUOTE) begin
          close_token(K_STR);
          lex_state = M_IDLE;
        end else if (c == CH_BSLASH) begin
          lex_state = M_ESC;
        end else begin
          push_word(K_STR, c, 1'b1, 1'b0);
        end
      end
      M_ESC: begin
        if (eoi) begin
          close_token(K_ERR);
          start_token(c, eoi);
        end else begin
          case (c)
            CH_LOW_N: t = CH_LF;
            CH_LOW_T: t = CH_TAB;
            CH_LOW_F: t = CH_FF;
            default:  t = c;
          endcase
          push_word(K_STR, t, 1'b1, 1'b0);
          lex_state = M_STR;
        end
      end
      default: start_token(c, eoi);
    endcase
  endfunction

  function void report(string what, res_t want, res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected kind %0d char %02h has %0b last %0b, got kind %0d char %02h has %0b last %0b",
               $realtime, what, want.token_kind, want.value_char, want.has_char,
               want.last_of_token, got.token_kind, got.value_char, got.has_char,
               got.last_of_token);
  endfunction

  function void check_word(res_t got);
    res_t want;
    if (expected_words.size() == 0) begin
      report("unexpected token word", '0, got);
      return;
    end
    want = expected_words.pop_front();
    if (got.token_kind !== want.token_kind || got.value_char !== want.value_char ||
        got.has_char !== want.has_char || got.last_of_token !== want.last_of_token)
      report("token word differs", want, got);
  endfunction

  function int pending();
    return expected_words.size();
  endfunction
endclass

module testbench;

  // A run is stuck if no word moves on either channel for this many cycles. The
  // longest legal quiet stretch is the receiver hold-off plus a few random gaps.
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_WORDS  = 70;

  // Idle percentages per phase: none, sender only, receiver only, both.
  localparam int SEND_PCT [4] = '{0, 77, 0, 25};
  localparam int STALL_PCT[4] = '{0, 0, 77, 25};

  logic clk;
  logic rst;

  setok_in_if  bytes_if ();
  setok_out_if tokens_if ();

  s_expression_tokenizer u_dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes_if),
    .tokens (tokens_if)
  );

  token_scoreboard sb = new();

  int send_idle_pct;
  int stall_pct;
  int hold_left;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Pick a whitespace byte: TAB, LF, VT, FF, CR or space.
  function automatic logic [7:0] random_space();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
  endfunction

  function automatic logic [7:0] random_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  // Offer one source word, idling first at the rate of the current phase. The
  // valid line is only written once per edge: either lowered for a gap or raised
  // with the new payload, so back-to-back words keep it high.
  task automatic send_byte(logic [7:0] c, logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      bytes_if.valid <= 1'b0;
      @(posedge clk);
    end
    bytes_if.valid        <= 1'b1;
    bytes_if.char_in      <= c;
    bytes_if.end_of_input <= eoi;
    do @(posedge clk); while (!bytes_if.ready);
    sb.note_byte(c, eoi);
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // Build one random piece of source text and send it. Most pieces are
  // well-formed tokens with random content; some are raw noise, stray end marks
  // and tokens cut short by the end of input. Bit 8 of a text entry is the end
  // mark. Whitespace and comments do not count toward the word budget, since the
  // lexer just drops them.
  task automatic send_random_piece(inout int words_left);
    logic [8:0] text[$];
    logic [7:0] c;
    bit         skipped;
    int         n;
    skipped = 1'b0;
    case ($urandom_range(13))
      0, 1, 2: begin
        // Integer, optionally signed, maybe extended into a rational or a decimal.
        if ($urandom_range(2) == 0) text.push_back({1'b0, CH_MINUS});
        n = $urandom_range(1, 4);
        repeat (n) text.push_back({1'b0, random_digit()});
        case ($urandom_range(3))
          1: begin
            text.push_back({1'b0, CH_SLASH});
            if ($urandom_range(1) == 1) text.push_back({1'b0, CH_MINUS});
            n = $urandom_range(0, 3);
            repeat (n) text.push_back({1'b0, random_digit()});
          end
          2: begin
            text.push_back({1'b0, CH_DOT});
            n = $urandom_range(0, 3);
            repeat (n) text.push_back({1'b0, random_digit()});
          end
          default: ;
        endcase
      end
      3, 4: begin
        // Symbol: a letter-range start, then any byte that does not end it.
        text.push_back({1'b0, 8'($urandom_range(8'h41, 8'h7a))});
        n = $urandom_range(0, 5);
        repeat (n) begin
          c = 8'($urandom_range(8'h21, 8'hff));
          if (c == CH_RPAREN) c = CH_LOW_F;
          text.push_back({1'b0, c});
        end
      end
      5: begin
        text.push_back({1'b0, CH_HASH});
        n = $urandom_range(1, 4);
        repeat (n) text.push_back({1'b0, 8'($urandom_range(8'h61, 8'h7a))});
      end
      6, 7: begin
        // String with random bytes and escapes, nearly always closed.
        text.push_back({1'b0, CH_QUOTE});
        n = $urandom_range(0, 6);
        repeat (n) begin
          if ($urandom_range(3) == 0) begin
            text.push_back({1'b0, CH_BSLASH});
            case ($urandom_range(3))
              0: c = CH_LOW_N;
              1: c = CH_LOW_T;
              2: c = CH_LOW_F;
              default: c = 8'($urandom_range(255));
            endcase
          end else begin
            c = 8'($urandom_range(255));
            if (c == CH_QUOTE || c == CH_BSLASH) c = CH_HASH;
          end
          text.push_back({1'b0, c});
        end
        if ($urandom_range(9) != 0) text.push_back({1'b0, CH_QUOTE});
        else text.push_back({1'b1, 8'($urandom_range(255))});
      end
      8: begin
        case ($urandom_range(3))
          0: text.push_back({1'b0, CH_LPAREN});
          1: text.push_back({1'b0, CH_RPAREN});
          2: text.push_back({1'b0, CH_DOT});
          default: text.push_back({1'b0, CH_TICK});
        endcase
      end
      9: begin
        skipped = 1'b1;
        text.push_back({1'b0, CH_SEMI});
        n = $urandom_range(0, 6);
        repeat (n) begin
          c = 8'($urandom_range(255));
          if (c == CH_LF) c = CH_SPACE;
          text.push_back({1'b0, c});
        end
        text.push_back({1'b0, CH_LF});
      end
      10: begin
        skipped = 1'b1;
        n = $urandom_range(1, 3);
        repeat (n) text.push_back({1'b0, random_space()});
      end
      11: begin
        n = $urandom_range(1, 3);
        repeat (n) text.push_back({1'b0, 8'($urandom_range(255))});
      end
      12: text.push_back({1'b1, 8'($urandom_range(255))});
      default: begin
        // A token cut off by the end of input.
        case ($urandom_range(3))
          0: begin
            text.push_back({1'b0, CH_QUOTE});
            n = $urandom_range(0, 3);
            repeat (n) text.push_back({1'b0, 8'($urandom_range(8'h61, 8'h7a))});
          end
          1: begin
            text.push_back({1'b0, CH_QUOTE});
            text.push_back({1'b0, CH_BSLASH});
          end
          2: text.push_back({1'b0, CH_MINUS});
          default: begin
            text.push_back({1'b0, random_digit()});
            text.push_back({1'b0, CH_SLASH});
          end
        endcase
        text.push_back({1'b1, 8'($urandom_range(255))});
      end
    endcase
    // Usually separate the piece from the next one; sometimes let them run together.
    if ($urandom_range(3) != 0) begin
      if ($urandom_range(4) == 0) text.push_back({1'b0, CH_RPAREN});
      else text.push_back({1'b0, random_space()});
    end
    foreach (text[i]) send_byte(text[i][7:0], text[i][8]);
    if (!skipped) words_left -= text.size();
  endtask

  // Result side: check every accepted word, then pick ready for the next edge.
  // A hold-off request keeps ready low for a long run so the block backs up and
  // pushes back on its input.
  always @(posedge clk) begin
    res_t got;
    if (rst) begin
      tokens_if.ready <= 1'b0;
    end else begin
      if (tokens_if.valid && tokens_if.ready) begin
        got.token_kind    = tokens_if.token_kind;
        got.value_char    = tokens_if.value_char;
        got.has_char      = tokens_if.has_char;
        got.last_of_token = tokens_if.last_of_token;
        sb.check_word(got);
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        tokens_if.ready <= 1'b0;
      end else begin
        tokens_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: counts edges at which no word moves on either channel.
  always @(posedge clk) begin
    if (rst || (bytes_if.valid && bytes_if.ready) || (tokens_if.valid && tokens_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int words_left;
    rst                   = 1'b1;
    bytes_if.valid        = 1'b0;
    bytes_if.char_in      = CH_NUL;
    bytes_if.end_of_input = 1'b0;
    tokens_if.ready       = 1'b0;
    send_idle_pct         = 0;
    stall_pct             = 0;
    hold_left             = 0;
    quiet_cycles          = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed text. It covers a signed rational with a signed denominator ended
    // by a dot, a decimal ended by a second dot, a constant with ';' inside it, a
    // comment, a tick, a string with a translated and a kept escape that is left
    // open at the end of input, a second end mark while idle, the byte extremes
    // inside a symbol closed by ')', and a lone minus right before the end.
    send_string("(-7/-2.1.5.#t; ;\n'\"\\n\\q");
    send_byte(8'($urandom_range(255)), 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(CH_NUL, 1'b0);
    send_byte(CH_RPAREN, 1'b0);
    send_byte(CH_MINUS, 1'b0);
    send_byte(CH_NUL, 1'b1);

    // Random text in four idling phases. The first one also holds the result side
    // off for a long stretch while the source keeps offering words.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = SEND_PCT[p];
      stall_pct     = STALL_PCT[p];
      if (p == 0) hold_left = HOLD_CYCLES;
      words_left = PHASE_WORDS;
      while (words_left > 0) send_random_piece(words_left);
    end

    // Drain: wait for every predicted word, then give stray words time to show up.
    bytes_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/setok_pkg.sv
design/setok_in_if.sv
design/setok_out_if.sv
design/setok_lex.sv
design/setok_emit.sv
design/s_expression_tokenizer.sv
tb/testbench.sv
